[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is low.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error(msg);

// Clocked assertion that is also checked while reset is low.
`define ASSERT_CLK_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/usv_pkg.sv]
// ----------------------------------------------------------------------------
// usv_pkg
// Types and constants of the sphere vertex generator.
// ----------------------------------------------------------------------------
package usv_pkg;

    localparam int SEG_W        = 9;
    localparam int MAX_SEGMENTS = 256;
    localparam int FRAC_BITS    = 14;
    localparam int PH_W         = 32;
    localparam int ADDR_W       = 3;

    localparam logic [SEG_W-1:0] SEG_RESET = 9'd48;

    // Register index of the segment count.
    localparam logic [0:0] REG_SEGMENTS = 1'b0;

    localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
    localparam logic [30:0] Q30_HPI  = 31'd1686629713;

    localparam int N_SIN = 6;
    localparam int N_COS = 7;
    localparam int SIN_DV [N_SIN] = '{156, 110, 72, 42, 20, 6};
    localparam int COS_DV [N_COS] = '{182, 132, 90, 56, 30, 12, 2};

    // Fold, angle scale and square, the cosine series, then quadrant mapping.
    localparam int TRIG_LAT = 3 + 2 * N_COS + 1;

    typedef struct packed {
        logic [30:0] sm;
        logic        sn;
        logic [30:0] cm;
        logic        cn;
    } t_trig;

    typedef struct packed {
        logic        pad;
        logic [15:0] tangent_z;
        logic [15:0] tangent_x;
        logic [15:0] tex_v;
        logic [14:0] tex_u;
        logic [15:0] pos_z;
        logic [15:0] pos_y;
        logic [15:0] pos_x;
    } t_result;

endpackage

[design/usv_delay.sv]
// ----------------------------------------------------------------------------
// usv_delay
// Enabled shift line that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
module usv_delay #(
    parameter int W = 1,
    parameter int D = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_d
);

    logic [W-1:0] r_d [D];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d[0] <= i_d;
            for (int k = 1; k < D; k++) begin
                r_d[k] <= r_d[k-1];
            end
        end
    end

    assign o_d = r_d[D-1];

endmodule

[design/usv_div.sv]
// ----------------------------------------------------------------------------
// usv_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module usv_div #(
    parameter int QW = 32,
    parameter int DW = 9
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [DW-1:0] i_hi,
    input  logic [QW-1:0] i_lo,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo
);

    logic [DW-1:0] r_rem [QW];
    logic [DW-1:0] r_den [QW];
    logic [QW-1:0] r_lo  [QW];
    logic [QW-1:0] r_q   [QW];

    for (genvar k = 0; k < QW; k++) begin : g_st
        logic [DW-1:0] w_rem;
        logic [DW-1:0] w_den;
        logic [QW-1:0] w_lo;
        logic [QW-1:0] w_q;
        logic [DW:0]   w_t;
        logic [DW:0]   n_t;
        logic          w_ge;

        if (k == 0) begin : g_first
            assign w_rem = i_hi;
            assign w_den = i_den;
            assign w_lo  = i_lo;
            assign w_q   = '0;
        end else begin : g_next
            assign w_rem = r_rem[k-1];
            assign w_den = r_den[k-1];
            assign w_lo  = r_lo[k-1];
            assign w_q   = r_q[k-1];
        end

        assign w_t  = {w_rem, w_lo[QW-1]};
        assign w_ge = w_t >= {1'b0, w_den};
        assign n_t  = w_ge ? w_t - {1'b0, w_den} : w_t;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_t[DW-1:0];
                r_den[k] <= w_den;
                r_lo[k]  <= {w_lo[QW-2:0], 1'b0};
                r_q[k]   <= {w_q[QW-2:0], w_ge};
            end
        end
    end

    assign o_quo = r_q[QW-1];

endmodule

[design/usv_step.sv]
// ----------------------------------------------------------------------------
// usv_step
// One Horner step of a truncating series: t = 1 - ((x2 * t) >> 30) / DV.
// ----------------------------------------------------------------------------
module usv_step #(
    parameter int DV = 2
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [29:0] i_x,
    input  logic [29:0] i_x2,
    input  logic [30:0] i_t,
    output logic [29:0] o_x,
    output logic [29:0] o_x2,
    output logic [30:0] o_t
);

    // Exact floor division by DV through a 32-bit reciprocal.
    localparam int          L   = $clog2(DV);
    localparam int          SH  = 31 + L;
    localparam logic [63:0] M64 = ((64'd1 << SH) + 64'(DV) - 64'd1) / 64'(DV);
    localparam logic [31:0] M   = M64[31:0];

    logic [60:0] w_p;
    logic [60:0] r_p;
    logic [61:0] w_v;
    logic [61:0] r_v;
    logic [29:0] r_xa;
    logic [29:0] r_x2a;
    logic [29:0] r_xb;
    logic [29:0] r_x2b;

    assign w_p = i_x2 * i_t;
    assign w_v = r_p[59:30] * M;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p   <= w_p;
            r_xa  <= i_x;
            r_x2a <= i_x2;
            r_v   <= w_v;
            r_xb  <= r_xa;
            r_x2b <= r_x2a;
        end
    end

    assign o_x  = r_xb;
    assign o_x2 = r_x2b;
    assign o_t  = usv_pkg::Q30_ONE - 31'(r_v >> SH);

endmodule

[design/usv_trig.sv]
// ----------------------------------------------------------------------------
// usv_trig
// Sine and cosine of a 32-bit phase as Q30 magnitudes with sign flags.
// ----------------------------------------------------------------------------
module usv_trig (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [31:0]         i_phase,
    output usv_pkg::t_trig      o_trig
);

    localparam int NS = usv_pkg::N_SIN;
    localparam int NC = usv_pkg::N_COS;

    logic [29:0] w_r;
    logic        w_hi;
    logic [29:0] w_rr;
    logic [60:0] r_prod;
    logic [2:0]  r_qh;
    logic [29:0] r_th;
    logic [60:0] w_th;
    logic [59:0] w_sq;
    logic [29:0] r_x2;
    logic [29:0] r_th3;

    assign w_r  = i_phase[29:0];
    assign w_hi = w_r > 30'h2000_0000;
    assign w_rr = w_hi ? 30'(usv_pkg::Q30_ONE - {1'b0, w_r}) : w_r;
    assign w_th = r_prod + 61'h2000_0000;
    assign w_sq = r_th * r_th;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= w_rr * usv_pkg::Q30_HPI;
            r_qh   <= {i_phase[31:30], w_hi};
            r_th   <= w_th[59:30];
            r_x2   <= w_sq[59:30];
            r_th3  <= r_th;
        end
    end

    logic [29:0] s_x  [NS+1];
    logic [29:0] s_x2 [NS+1];
    logic [30:0] s_t  [NS+1];
    logic [29:0] c_x  [NC+1];
    logic [29:0] c_x2 [NC+1];
    logic [30:0] c_t  [NC+1];

    assign s_x[0]  = r_th3;
    assign s_x2[0] = r_x2;
    assign s_t[0]  = usv_pkg::Q30_ONE;
    assign c_x[0]  = r_th3;
    assign c_x2[0] = r_x2;
    assign c_t[0]  = usv_pkg::Q30_ONE;

    for (genvar k = 0; k < NS; k++) begin : g_sin
        usv_step #(.DV(usv_pkg::SIN_DV[k])) u_step (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_x   (s_x[k]),
            .i_x2  (s_x2[k]),
            .i_t   (s_t[k]),
            .o_x   (s_x[k+1]),
            .o_x2  (s_x2[k+1]),
            .o_t   (s_t[k+1])
        );
    end

    for (genvar k = 0; k < NC; k++) begin : g_cos
        usv_step #(.DV(usv_pkg::COS_DV[k])) u_step (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_x   (c_x[k]),
            .i_x2  (c_x2[k]),
            .i_t   (c_t[k]),
            .o_x   (c_x[k+1]),
            .o_x2  (c_x2[k+1]),
            .o_t   (c_t[k+1])
        );
    end

    logic [60:0] w_smul;
    logic [29:0] r_smul;
    logic [29:0] r_sdel;
    logic [2:0]  w_qh;
    logic [30:0] w_s0;
    logic [30:0] w_c0;
    usv_pkg::t_trig n_trig;
    usv_pkg::t_trig r_trig;

    assign w_smul = s_x[NS] * s_t[NS];

    usv_delay #(.W(3), .D(2 * NC + 2)) u_qh (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_d   (r_qh),
        .o_d   (w_qh)
    );

    assign w_s0 = w_qh[0] ? c_t[NC] : {1'b0, r_sdel};
    assign w_c0 = w_qh[0] ? {1'b0, r_sdel} : c_t[NC];

    always_comb begin
        case (w_qh[2:1])
            2'd0: n_trig = '{sm: w_s0, sn: 1'b0, cm: w_c0, cn: 1'b0};
            2'd1: n_trig = '{sm: w_c0, sn: 1'b0, cm: w_s0, cn: 1'b1};
            2'd2: n_trig = '{sm: w_s0, sn: 1'b1, cm: w_c0, cn: 1'b1};
            default: n_trig = '{sm: w_c0, sn: 1'b1, cm: w_s0, cn: 1'b0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_smul <= w_smul[59:30];
            r_sdel <= r_smul;
            r_trig <= n_trig;
        end
    end

    assign o_trig = r_trig;

endmodule

[design/uv_sphere_vertex_generator.sv]
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator
// Position, texture coordinates and tangent of one latitude-longitude grid
// point per item.
// ----------------------------------------------------------------------------
//  Channel   | Direction | Carries
//  s_axis    | in        | tdata: ring, sector
//  m_axis    | out       | tdata: pos_x, pos_y, pos_z, tex_u, tex_v, tangent_x,
//            |           |        tangent_z
//  APB       | in/out    | segments at byte address 0
//
// One item enters per cycle while s_axis_tready is high; each item passes
// the input register, the 32-stage phase dividers, the 18-stage sine and
// cosine blocks and the product, result and output registers, in order.
// Reset clears all valid bits and sets segments to 48.
// A skid register behind the output register lets a stalled output hold
// without losing or repeating items; the input stalls only once it is full.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [23:0]                s_axis_tdata,   // ring, sector, zero pad
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [111:0]               m_axis_tdata,   // pos_x, pos_y, pos_z,
                                                       // tex_u, tex_v, tangent_x,
                                                       // tangent_z, zero pad
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [usv_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int SW      = usv_pkg::SEG_W;
    localparam int FB      = usv_pkg::FRAC_BITS;
    localparam int ST_PH   = 1 + usv_pkg::PH_W;
    localparam int ST_TRIG = ST_PH + usv_pkg::TRIG_LAT;
    localparam int ST_PROD = ST_TRIG + 1;
    localparam int N_ST    = ST_PROD + 1;
    localparam int D_POLE  = ST_PROD - 1;
    localparam int D_TU    = ST_PROD - (1 + FB + 1);
    localparam int D_TV    = ST_PROD - (1 + FB + 2);
    localparam int SH_P    = 60 - FB;
    localparam int SH_Y    = 30 - FB;

    // Configuration.
    logic [SW-1:0] r_seg;
    logic          w_wr;

    assign w_wr   = psel && penable && pwrite && (paddr[2] == usv_pkg::REG_SEGMENTS);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == usv_pkg::REG_SEGMENTS) ? 32'(r_seg) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg <= usv_pkg::SEG_RESET;
        end else if (w_wr) begin
            r_seg <= pwdata[SW-1:0];
        end
    end

    // Flow control.
    logic w_en;
    logic r_sk_v;
    logic r_out_v;
    logic [N_ST-1:0] r_vld;

    assign w_en          = !r_sk_v;
    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[N_ST-2:0], s_axis_tvalid};
        end
    end

    // Input stage: clamp segments, saturate ring and sector, wrap the last sector to zero.
    logic [SW-1:0] w_seg;
    logic [SW-1:0] w_ring;
    logic [SW-1:0] w_sec;
    logic [SW-1:0] w_ring_s;
    logic [SW-1:0] w_sec_s;
    logic [SW-1:0] r1_seg;
    logic [SW-1:0] r1_ring;
    logic [SW-1:0] r1_sec;
    logic [SW-1:0] r1_sec_w;

    assign w_ring = s_axis_tdata[SW-1:0];
    assign w_sec  = s_axis_tdata[2*SW-1:SW];

    always_comb begin
        if (r_seg == '0) begin
            w_seg = SW'(1);
        end else if (r_seg > SW'(usv_pkg::MAX_SEGMENTS)) begin
            w_seg = SW'(usv_pkg::MAX_SEGMENTS);
        end else begin
            w_seg = r_seg;
        end
    end

    assign w_ring_s = (w_ring > w_seg) ? w_seg : w_ring;
    assign w_sec_s  = (w_sec > w_seg) ? w_seg : w_sec;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_seg   <= w_seg;
            r1_ring  <= w_ring_s;
            r1_sec   <= w_sec_s;
            r1_sec_w <= (w_sec_s == w_seg) ? '0 : w_sec_s;
        end
    end

    // Phases and texture quotients.
    logic [31:0]   w_ph_a;
    logic [31:0]   w_ph_p;
    logic [FB:0]   w_tu_q;
    logic [FB+1:0] w_tv_q;
    logic [FB:0]   w_tu;
    logic [FB+1:0] w_tv;
    logic          w_pole;

    usv_div #(.QW(usv_pkg::PH_W), .DW(SW + 1)) u_div_a (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_hi  ({1'b0, r1_ring}),
        .i_lo  (32'(r1_seg)),
        .i_den ({r1_seg, 1'b0}),
        .o_quo (w_ph_a)
    );

    usv_div #(.QW(usv_pkg::PH_W), .DW(SW)) u_div_p (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_hi  (r1_sec_w),
        .i_lo  (32'(r1_seg >> 1)),
        .i_den (r1_seg),
        .o_quo (w_ph_p)
    );

    usv_div #(.QW(FB + 1), .DW(SW)) u_div_u (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_hi  (r1_ring >> 1),
        .i_lo  ({r1_ring[0], FB'(r1_seg >> 1)}),
        .i_den (r1_seg),
        .o_quo (w_tu_q)
    );

    usv_div #(.QW(FB + 2), .DW(SW)) u_div_v (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_hi  (r1_sec >> 1),
        .i_lo  ({r1_sec[0], (FB + 1)'(r1_seg >> 1)}),
        .i_den (r1_seg),
        .o_quo (w_tv_q)
    );

    usv_delay #(.W(FB + 1), .D(D_TU)) u_dly_u (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (w_tu_q),
        .o_d   (w_tu)
    );

    usv_delay #(.W(FB + 2), .D(D_TV)) u_dly_v (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (w_tv_q),
        .o_d   (w_tv)
    );

    usv_delay #(.W(1), .D(D_POLE)) u_dly_pole (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   ((r1_ring == '0) || (r1_ring == r1_seg)),
        .o_d   (w_pole)
    );

    // Sine and cosine of both angles.
    usv_pkg::t_trig w_ta;
    usv_pkg::t_trig w_tp;

    usv_trig u_trig_a (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_phase (w_ph_a),
        .o_trig  (w_ta)
    );

    usv_trig u_trig_p (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_phase (w_ph_p),
        .o_trig  (w_tp)
    );

    // Products.
    logic [61:0] r_pm;
    logic [61:0] r_bm;
    logic        r_pn;
    logic        r_bn;
    logic [30:0] r_ym;
    logic        r_yn;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pm <= w_tp.cm * w_ta.sm;
            r_bm <= w_tp.sm * w_ta.sm;
            r_pn <= (w_tp.cn == w_ta.sn);
            r_bn <= (w_tp.sn != w_ta.sn);
            r_ym <= w_ta.cm;
            r_yn <= !w_ta.cn;
        end
    end

    // Rounding and assembly.
    logic [61:0]      w_pr;
    logic [61:0]      w_br;
    logic [30:0]      w_yr;
    logic [15:0]      w_pxm;
    logic [15:0]      w_pzm;
    logic [15:0]      w_pym;
    logic [15:0]      w_px;
    logic [15:0]      w_pz;
    logic [15:0]      w_py;
    usv_pkg::t_result n_res;
    usv_pkg::t_result r_res;
    usv_pkg::t_result r_out;
    usv_pkg::t_result r_sk;

    assign w_pr  = r_pm + (62'd1 << (SH_P - 1));
    assign w_br  = r_bm + (62'd1 << (SH_P - 1));
    assign w_yr  = r_ym + (31'd1 << (SH_Y - 1));
    assign w_pxm = 16'(w_pr >> SH_P);
    assign w_pzm = 16'(w_br >> SH_P);
    assign w_pym = 16'(w_yr >> SH_Y);
    assign w_px  = r_pn ? 16'(-w_pxm) : w_pxm;
    assign w_pz  = r_bn ? 16'(-w_pzm) : w_pzm;
    assign w_py  = r_yn ? 16'(-w_pym) : w_pym;

    always_comb begin
        n_res           = '0;
        n_res.pos_x     = w_px;
        n_res.pos_y     = w_py;
        n_res.pos_z     = w_pz;
        n_res.tex_u     = w_tu;
        n_res.tex_v     = w_tv;
        n_res.tangent_x = w_pole ? '0 : w_pz;
        n_res.tangent_z = w_pole ? 16'(-(17'd1 << FB)) : 16'(-w_px);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_res <= n_res;
        end
    end

    // Output register and skid register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_sk_v  <= 1'b0;
        end else if (m_axis_tready || !r_out_v) begin
            if (r_sk_v) begin
                r_out_v <= 1'b1;
                r_sk_v  <= 1'b0;
            end else begin
                r_out_v <= r_vld[N_ST-1];
            end
        end else if (w_en && r_vld[N_ST-1]) begin
            r_sk_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_axis_tready || !r_out_v) begin
            r_out <= r_sk_v ? r_sk : r_res;
        end else if (w_en) begin
            r_sk <= r_res;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out;

endmodule

[design/usv_checker.sv]
// ----------------------------------------------------------------------------
// usv_checker
// Port-level checks of the sphere vertex generator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module usv_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       s_axis_tvalid,
    input logic                       s_axis_tready,
    input logic [23:0]                s_axis_tdata,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [111:0]               m_axis_tdata,
    input logic                       psel,
    input logic                       penable,
    input logic                       pwrite,
    input logic [usv_pkg::ADDR_W-1:0] paddr,
    input logic [31:0]                pwdata,
    input logic [31:0]                prdata,
    input logic                       pready
);

    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled item changed")

    `ASSERT_CLK_NR(a_rst_idle, i_clk, !i_rst_n |=> !m_axis_tvalid, "item valid after reset")

    `ASSERT_CLK(a_pole, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tdata[62:48] == 15'd0) |-> (m_axis_tdata[94:79] == 16'd0) && (m_axis_tdata[110:95] == 16'hC000), "pole tangent wrong")

    `ASSERT_CLK(a_tex_u, i_clk, i_rst_n, m_axis_tvalid |-> m_axis_tdata[62:48] <= 15'd16384, "tex_u above one")

    `ASSERT_CLK(a_readback, i_clk, i_rst_n, psel && penable && pwrite && pready && !paddr[2] |=> paddr[2] || (prdata[8:0] == $past(pwdata[8:0])), "segments readback wrong")

endmodule

bind uv_sphere_vertex_generator usv_checker u_usv_checker (.*);
